// ----- rtl/ampsup_pkg.sv -----
// Package with shared types, register codes and constants of the supply tracking policy.
package ampsup_pkg;

   localparam int DEF_GAIN_TABLE_DEPTH = 1024;
   localparam int DEF_LOCK_WIDTH       = 16;

   typedef logic        [15:0] mv_type;
   typedef logic signed [11:0] vol_type;
   typedef logic        [2:0]  csr_index_type;

   typedef enum logic [1:0] {
      MODE_TICK   = 2'd0,
      MODE_VOLUME = 2'd1,
      MODE_STATUS = 2'd2,
      MODE_POWER  = 2'd3
   } mode_type;

   // Register indexes of the configuration port.
   localparam csr_index_type CSR_SUPPLY_MIN   = 3'd0;
   localparam csr_index_type CSR_SUPPLY_MAX   = 3'd1;
   localparam csr_index_type CSR_FULL_VOLUME  = 3'd2;
   localparam csr_index_type CSR_LOWER_LOCK   = 3'd3;
   localparam csr_index_type CSR_CLIP_LOCK    = 3'd4;
   localparam csr_index_type CSR_OTW_LOCK     = 3'd5;
   localparam csr_index_type CSR_WARN_LOCK    = 3'd6;
   localparam csr_index_type CSR_CLIP_HEADROOM = 3'd7;

   // Register reset values.
   localparam mv_type  RST_SUPPLY_MIN    = 16'd15000;
   localparam mv_type  RST_SUPPLY_MAX    = 16'd50000;
   localparam vol_type RST_FULL_VOLUME   = -12'sd32;
   localparam mv_type  RST_LOWER_LOCK    = 16'd1000;
   localparam mv_type  RST_CLIP_LOCK     = 16'd100;
   localparam mv_type  RST_OTW_LOCK      = 16'd1000;
   localparam mv_type  RST_WARN_LOCK     = 16'd1000;
   localparam mv_type  RST_CLIP_HEADROOM = 16'd5000;
   localparam vol_type RST_LAST_VOLUME   = -12'sd2048;

   // Q30 attenuation factors 10^(-2^j/320) for each bit j of the attenuation.
   localparam int ATTEN_BITS = 12;
   localparam logic [63:0] ATTEN_Q30 [ATTEN_BITS] = '{
      64'd1066043361, 64'd1058400094, 64'd1043277569, 64'd1013677647,
      64'd956973408,  64'd852903448,  64'd677485290,  64'd427464319,
      64'd170176611,  64'd26971175,   64'd677485,     64'd427
   };
   localparam logic [63:0] Q30_ONE  = 64'd1 << 30;
   localparam logic [63:0] Q30_HALF = 64'd1 << 29;

   // Division by ten of values below 2^18: multiply by this and shift right by 19.
   localparam logic [15:0] DIV10_MUL   = 16'd52429;
   localparam int          DIV10_SHIFT = 19;

   typedef struct packed {
      mode_type mode;
      logic     power_on;
      logic     amp_warn;
      logic     overtemp_flag;
      logic     clip_flag;
      mv_type   measured_supply_mv;
   } item_type;

endpackage

// ----- rtl/amp_supply_tracking_policy.sv -----
// Amplifier supply tracking policy: volume driven supply target with lock timers.
//
// Items enter on the req_ channel (valid/stall) and each one yields exactly one
// result on the rsp_ channel. A transaction completes at a rising edge with valid
// high and stall low. Tick, volume, status and power items may follow one another
// in every cycle; the block sustains one item per clock while the receiver does
// not stall. The accepting edge loads the input register and reads the gain ROM,
// the supply_max times gain product is registered in the product stage, and the
// result stage applies the target rule, updates the lock timers and loads the
// result register, from which the receiver takes the result.
// When the receiver stalls, the result holds in its register while items still
// move up into empty stages behind it; req_stall rises only once every stage is
// full. The gain ROM is a constant table built at elaboration, so no fill pass
// follows reset.
// Reset (synchronous, active high) empties the pipeline, clears the target and
// locks, sets the last volume to muted and loads the register reset values.
// Configuration writes on the csr_ channel are always accepted (csr_ready high)
// and must only be issued while no transaction is in flight.
module amp_supply_tracking_policy #(
   parameter int GAIN_TABLE_DEPTH = ampsup_pkg::DEF_GAIN_TABLE_DEPTH,
   parameter int LOCK_WIDTH       = ampsup_pkg::DEF_LOCK_WIDTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  ampsup_pkg::mode_type      req_mode,
   input  ampsup_pkg::vol_type       req_volume_db,
   input  logic                      req_power_on,
   input  logic                      req_amp_warn,
   input  logic                      req_overtemp_flag,
   input  logic                      req_clip_flag,
   input  ampsup_pkg::mv_type        req_measured_supply_mv,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ampsup_pkg::mv_type        rsp_supply_target_mv,
   output logic                      rsp_target_written,
   output logic                      rsp_reduce_volume,
   output logic                      rsp_safety_event,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  ampsup_pkg::csr_index_type csr_index,
   input  ampsup_pkg::mv_type        csr_data
);
   import ampsup_pkg::*;

   localparam int IDX_W  = $clog2(GAIN_TABLE_DEPTH);
   localparam int GAIN_W = 31;
   localparam int PROD_W = 16 + GAIN_W;

   typedef logic [GAIN_W-1:0] gain_rom_type [GAIN_TABLE_DEPTH];
   typedef logic [LOCK_WIDTH-1:0] lock_type;

   // Entry a holds the Q30 gain for an attenuation of a sixteenths of a dB.
   function automatic gain_rom_type build_gain_rom();
      gain_rom_type rom;
      logic [63:0]  g;
      for (int i = 0; i < GAIN_TABLE_DEPTH; i++) begin
         g = Q30_ONE;
         for (int j = 0; j < ATTEN_BITS; j++) begin
            if (i[j]) begin
               g = (g * ATTEN_Q30[j] + Q30_HALF) >> 30;
            end
         end
         rom[i] = g[GAIN_W-1:0];
      end
      return rom;
   endfunction

   localparam gain_rom_type GAIN_ROM = build_gain_rom();

   // Configuration registers.
   mv_type   cfg_min_ff, cfg_max_ff, cfg_headroom_ff;
   vol_type  cfg_full_volume_ff;
   mv_type   cfg_lower_ticks_ff, cfg_clip_ticks_ff, cfg_otw_ticks_ff, cfg_warn_ticks_ff;

   // Pipeline.
   logic                 s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic                 s1_valid_in, s2_valid_in, rsp_valid_in;
   item_type             s1_item_ff, s2_item_ff;
   logic [GAIN_W-1:0]    s1_gain_ff;
   logic [PROD_W-1:0]    s2_prod_ff;
   logic                 req_accept, s1_move, s2_move, s2_free, rsp_free;

   // Policy state.
   mv_type   target_ff, target_in;
   logic     known_ff, known_in;
   vol_type  last_volume_ff;
   lock_type lower_lock_ff, lower_lock_in;
   lock_type clip_lock_ff, clip_lock_in;
   lock_type otw_lock_ff, otw_lock_in;
   lock_type warn_lock_ff, warn_lock_in;

   // Result register.
   mv_type   rsp_target_ff;
   logic     rsp_written_ff, rsp_reduce_ff, rsp_safety_ff;
   logic     written_in, reduce_in, safety_in;

   // Front end.
   vol_type           vol_eff;
   logic signed [12:0] atten;
   logic [IDX_W-1:0]  rom_idx;

   // Target rule.
   logic [PROD_W-1:0] prod_round;
   mv_type            desired_raw, desired;
   logic [16:0]       clip_x, clip_sum;
   logic [32:0]       clip_prod;
   mv_type            clip_cand, cand;
   logic              try_apply, apply_raise, apply_lower, lock_open, status_done;
   lock_type          lower_reload, clip_reload, otw_reload, warn_reload;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_min_ff         <= RST_SUPPLY_MIN;
         cfg_max_ff         <= RST_SUPPLY_MAX;
         cfg_full_volume_ff <= RST_FULL_VOLUME;
         cfg_lower_ticks_ff <= RST_LOWER_LOCK;
         cfg_clip_ticks_ff  <= RST_CLIP_LOCK;
         cfg_otw_ticks_ff   <= RST_OTW_LOCK;
         cfg_warn_ticks_ff  <= RST_WARN_LOCK;
         cfg_headroom_ff    <= RST_CLIP_HEADROOM;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_SUPPLY_MIN:    cfg_min_ff         <= csr_data;
            CSR_SUPPLY_MAX:    cfg_max_ff         <= csr_data;
            CSR_FULL_VOLUME:   cfg_full_volume_ff <= csr_data[11:0];
            CSR_LOWER_LOCK:    cfg_lower_ticks_ff <= csr_data;
            CSR_CLIP_LOCK:     cfg_clip_ticks_ff  <= csr_data;
            CSR_OTW_LOCK:      cfg_otw_ticks_ff   <= csr_data;
            CSR_WARN_LOCK:     cfg_warn_ticks_ff  <= csr_data;
            CSR_CLIP_HEADROOM: cfg_headroom_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Handshake: each stage moves when the one after it is empty or moving.
   always_comb begin
      rsp_free     = !rsp_valid_ff || !rsp_stall;
      s2_move      = s2_valid_ff && rsp_free;
      s2_free      = !s2_valid_ff || s2_move;
      s1_move      = s1_valid_ff && s2_free;
      req_stall    = s1_valid_ff && !s2_free;
      req_accept   = req_valid && !req_stall;
      s1_valid_in  = req_accept || (s1_valid_ff && !s2_free);
      s2_valid_in  = s1_move || (s2_valid_ff && !rsp_free);
      rsp_valid_in = s2_move || (rsp_valid_ff && rsp_stall);
   end

   // Gain ROM address from the attenuation, saturated to the table.
   always_comb begin
      vol_eff = (req_mode == MODE_VOLUME) ? req_volume_db : last_volume_ff;
      atten   = 13'(cfg_full_volume_ff) - 13'(vol_eff);
      if (atten <= 13'sd0) begin
         rom_idx = '0;
      end else if (int'(atten) > GAIN_TABLE_DEPTH - 1) begin
         rom_idx = IDX_W'(GAIN_TABLE_DEPTH - 1);
      end else begin
         rom_idx = atten[IDX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         last_volume_ff <= RST_LAST_VOLUME;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_accept && req_mode == MODE_VOLUME) begin
            last_volume_ff <= req_volume_db;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_item_ff <= '{mode: req_mode, power_on: req_power_on,
                         amp_warn: req_amp_warn,
                         overtemp_flag: req_overtemp_flag,
                         clip_flag: req_clip_flag,
                         measured_supply_mv: req_measured_supply_mv};
         s1_gain_ff <= GAIN_ROM[rom_idx];
      end
      if (s1_move) begin
         s2_item_ff <= s1_item_ff;
         s2_prod_ff <= PROD_W'(cfg_max_ff) * PROD_W'(s1_gain_ff);
      end
   end

   // Desired target and clipping candidate.
   always_comb begin
      prod_round  = s2_prod_ff + PROD_W'(Q30_HALF);
      desired_raw = prod_round[45:30];
      if (desired_raw < cfg_min_ff) begin
         desired = cfg_min_ff;
      end else if (desired_raw > cfg_max_ff) begin
         desired = cfg_max_ff;
      end else begin
         desired = desired_raw;
      end
      // round(1.1 * target) is target + (target + 5) / 10.
      clip_x    = 17'(target_ff) + 17'd5;
      clip_prod = 33'(clip_x) * 33'(DIV10_MUL);
      clip_sum  = 17'(target_ff) + 17'(clip_prod >> DIV10_SHIFT);
      if (clip_sum > 17'(cfg_max_ff)) begin
         clip_cand = cfg_max_ff;
      end else begin
         clip_cand = clip_sum[15:0];
      end
      cand = (s2_item_ff.mode == MODE_STATUS) ? clip_cand : desired;
   end

   // Target rule, status responses and lock timers.
   always_comb begin
      lower_reload  = LOCK_WIDTH'(cfg_lower_ticks_ff);
      clip_reload   = LOCK_WIDTH'(cfg_clip_ticks_ff);
      otw_reload    = LOCK_WIDTH'(cfg_otw_ticks_ff);
      warn_reload   = LOCK_WIDTH'(cfg_warn_ticks_ff);
      target_in     = target_ff;
      known_in      = known_ff;
      lower_lock_in = lower_lock_ff;
      clip_lock_in  = clip_lock_ff;
      otw_lock_in   = otw_lock_ff;
      warn_lock_in  = warn_lock_ff;
      written_in    = 1'b0;
      reduce_in     = 1'b0;
      safety_in     = 1'b0;
      try_apply     = 1'b0;
      status_done   = 1'b0;
      // On a tick the rule only runs when the lowering lock has just expired.
      lock_open     = (s2_item_ff.mode == MODE_TICK) || (lower_lock_ff == '0);
      apply_raise   = !known_ff || (target_ff < cand);
      apply_lower   = ((19'(target_ff) * 19'd5) > (19'(cand) * 19'd6)) && lock_open;

      case (s2_item_ff.mode)
         MODE_TICK: begin
            if (lower_lock_ff != '0) begin
               lower_lock_in = lower_lock_ff - LOCK_WIDTH'(1);
               try_apply     = (lower_lock_ff == LOCK_WIDTH'(1));
            end
            if (clip_lock_ff != '0) clip_lock_in = clip_lock_ff - LOCK_WIDTH'(1);
            if (otw_lock_ff != '0)  otw_lock_in  = otw_lock_ff - LOCK_WIDTH'(1);
            if (warn_lock_ff != '0) warn_lock_in = warn_lock_ff - LOCK_WIDTH'(1);
         end
         MODE_VOLUME: begin
            try_apply = 1'b1;
         end
         MODE_POWER: begin
            if (s2_item_ff.power_on) begin
               try_apply = 1'b1;
            end else begin
               lower_lock_in = lower_reload;
               target_in     = cfg_min_ff;
               known_in      = 1'b1;
               written_in    = 1'b1;
            end
         end
         MODE_STATUS: begin
            if (s2_item_ff.amp_warn) begin
               if (warn_lock_ff == '0) begin
                  warn_lock_in = warn_reload;
                  reduce_in    = 1'b1;
                  safety_in    = 1'b1;
                  status_done  = 1'b1;
               end
            end else begin
               warn_lock_in = '0;
            end
            if (!status_done) begin
               if (s2_item_ff.overtemp_flag) begin
                  if (otw_lock_ff == '0) begin
                     otw_lock_in = otw_reload;
                     reduce_in   = 1'b1;
                     status_done = 1'b1;
                  end
               end else begin
                  otw_lock_in = '0;
               end
            end
            if (!status_done && s2_item_ff.clip_flag && clip_lock_ff == '0) begin
               clip_lock_in = clip_reload;
               // Skip the boost while a rise is still under way or at maximum.
               if (known_ff && target_ff < cfg_max_ff &&
                   17'(target_ff) <= 17'(s2_item_ff.measured_supply_mv) + 17'(cfg_headroom_ff)) begin
                  try_apply = 1'b1;
               end
            end
         end
         default: ;
      endcase

      if (try_apply && (apply_raise || apply_lower)) begin
         target_in  = cand;
         known_in   = 1'b1;
         written_in = 1'b1;
         if (!apply_raise) begin
            lower_lock_in = lower_reload;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         known_ff      <= 1'b0;
         lower_lock_ff <= '0;
         clip_lock_ff  <= '0;
         otw_lock_ff   <= '0;
         warn_lock_ff  <= '0;
      end else if (s2_move) begin
         target_ff     <= target_in;
         known_ff      <= known_in;
         lower_lock_ff <= lower_lock_in;
         clip_lock_ff  <= clip_lock_in;
         otw_lock_ff   <= otw_lock_in;
         warn_lock_ff  <= warn_lock_in;
      end
   end

   // The target stays zero until one is first applied.
   always_ff @(posedge clock) begin
      if (s2_move) begin
         rsp_target_ff  <= target_in;
         rsp_written_ff <= written_in;
         rsp_reduce_ff  <= reduce_in;
         rsp_safety_ff  <= safety_in;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_supply_target_mv = rsp_target_ff;
   assign rsp_target_written   = rsp_written_ff;
   assign rsp_reduce_volume    = rsp_reduce_ff;
   assign rsp_safety_event     = rsp_safety_ff;

endmodule

// ----- rtl/ampsup_checker.sv -----
// Port level checks of the supply tracking policy, bound to its top level.
module ampsup_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_supply_target_mv,
   input logic        rsp_target_written,
   input logic        rsp_reduce_volume,
   input logic        rsp_safety_event
);

   // A stalled result stays valid with stable target, written and reduce.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_supply_target_mv) &&
      $stable(rsp_target_written) && $stable(rsp_reduce_volume))
      else $error("stalled result transaction changed");

   // The pipeline is empty after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // With the result register empty the input side can never be stalled.
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while the pipeline drains freely");

   // A safety response always asks for a volume step down.
   a_safety_reduces: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_safety_event |-> rsp_reduce_volume)
      else $error("safety event without volume reduction");

   // A volume reduction ends the item before any target change.
   a_reduce_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_reduce_volume |-> !rsp_target_written)
      else $error("target written together with volume reduction");

endmodule

bind amp_supply_tracking_policy ampsup_checker u_ampsup_checker (.*);

// ----- tb/tb_top.sv -----
// Self-checking testbench for the amplifier supply tracking policy block.
module tb_top;
   import ampsup_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int RUN_LIMIT     = 8000000;
   localparam int DRAIN_CYCLES  = 6;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 180;

   typedef struct {
      mode_type mode;
      vol_type  volume;
      logic     power_on;
      logic     amp_warn;
      logic     overtemp_flag;
      logic     clip_flag;
      mv_type   measured;
   } policy_item_type;

   typedef struct {
      mv_type target;
      logic   written;
      logic   reduce;
      logic   safety;
   } supply_result_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   mode_type req_mode = MODE_TICK;
   vol_type  req_volume_db = '0;
   logic     req_power_on = 1'b0;
   logic     req_amp_warn = 1'b0;
   logic     req_overtemp_flag = 1'b0;
   logic     req_clip_flag = 1'b0;
   mv_type   req_measured_supply_mv = '0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   mv_type   rsp_supply_target_mv;
   logic     rsp_target_written;
   logic     rsp_reduce_volume;
   logic     rsp_safety_event;
   logic     csr_valid = 1'b0;
   logic     csr_ready;
   csr_index_type csr_index = CSR_SUPPLY_MIN;
   mv_type   csr_data = '0;

   // Predictor configuration and state.
   mv_type  cfg_min, cfg_max, cfg_lower, cfg_clip, cfg_otw, cfg_warn, cfg_headroom;
   vol_type cfg_knee;
   mv_type  tgt;
   logic    tgt_known;
   vol_type last_vol;
   logic [15:0] lower_lock, clip_lock, otw_lock, warn_lock;

   supply_result_type expected_supply[$];
   int  errors = 0;
   bit  gap_enable = 1'b0;
   bit  stall_enable = 1'b0;
   int  hold_cycles = 0;

   amp_supply_tracking_policy i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_mode(req_mode),
      .req_volume_db(req_volume_db), .req_power_on(req_power_on),
      .req_amp_warn(req_amp_warn), .req_overtemp_flag(req_overtemp_flag),
      .req_clip_flag(req_clip_flag),
      .req_measured_supply_mv(req_measured_supply_mv),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_supply_target_mv(rsp_supply_target_mv),
      .rsp_target_written(rsp_target_written),
      .rsp_reduce_volume(rsp_reduce_volume), .rsp_safety_event(rsp_safety_event),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic void reset_policy_model();
      cfg_min = RST_SUPPLY_MIN;     cfg_max = RST_SUPPLY_MAX;
      cfg_knee = RST_FULL_VOLUME;   cfg_lower = RST_LOWER_LOCK;
      cfg_clip = RST_CLIP_LOCK;     cfg_otw = RST_OTW_LOCK;
      cfg_warn = RST_WARN_LOCK;     cfg_headroom = RST_CLIP_HEADROOM;
      tgt = '0;
      tgt_known = 1'b0;
      last_vol = RST_LAST_VOLUME;
      lower_lock = '0; clip_lock = '0; otw_lock = '0; warn_lock = '0;
   endfunction

   // Supply target for a volume: max scaled by the Q30 gain, then clamped.
   function automatic mv_type desired_target(vol_type vol);
      int          att;
      logic [63:0] gain;
      logic [63:0] d;
      att = int'(cfg_knee) - int'(vol);
      gain = Q30_ONE;
      if (att > 0) begin
         if (att > DEF_GAIN_TABLE_DEPTH - 1) att = DEF_GAIN_TABLE_DEPTH - 1;
         for (int j = 0; j < ATTEN_BITS; j++)
            if (att[j]) gain = (gain * ATTEN_Q30[j] + Q30_HALF) >> 30;
      end
      d = ({48'd0, cfg_max} * gain + Q30_HALF) >> 30;
      if (d < {48'd0, cfg_min}) d = {48'd0, cfg_min};
      else if (d > {48'd0, cfg_max}) d = {48'd0, cfg_max};
      return d[15:0];
   endfunction

   // Raising always applies; lowering needs more than a 1.2x step and an open lock.
   function automatic logic apply_target(mv_type p);
      logic [31:0] cur5, new6;
      cur5 = {16'd0, tgt} * 32'd5;
      new6 = {16'd0, p} * 32'd6;
      if (!tgt_known || tgt < p) begin
      end else if (cur5 > new6 && lower_lock == 0) begin
         lower_lock = cfg_lower;
      end else begin
         return 1'b0;
      end
      tgt = p;
      tgt_known = 1'b1;
      return 1'b1;
   endfunction

   function automatic supply_result_type predict_supply_step(policy_item_type it);
      supply_result_type r;
      logic         done;
      logic [31:0]  raised;
      r.written = 1'b0;
      r.reduce = 1'b0;
      r.safety = 1'b0;
      done = 1'b0;
      case (it.mode)
         MODE_TICK: begin
            if (lower_lock > 0) begin
               lower_lock = lower_lock - 1'b1;
               if (lower_lock == 0) r.written = apply_target(desired_target(last_vol));
            end
            if (clip_lock > 0) clip_lock = clip_lock - 1'b1;
            if (otw_lock > 0) otw_lock = otw_lock - 1'b1;
            if (warn_lock > 0) warn_lock = warn_lock - 1'b1;
         end
         MODE_VOLUME: begin
            last_vol = it.volume;
            r.written = apply_target(desired_target(last_vol));
         end
         MODE_POWER: begin
            if (it.power_on) begin
               r.written = apply_target(desired_target(last_vol));
            end else begin
               lower_lock = cfg_lower;
               tgt = cfg_min;
               tgt_known = 1'b1;
               r.written = 1'b1;
            end
         end
         default: begin
            if (it.amp_warn) begin
               if (warn_lock == 0) begin
                  warn_lock = cfg_warn;
                  r.reduce = 1'b1;
                  r.safety = 1'b1;
                  done = 1'b1;
               end
            end else begin
               warn_lock = '0;
            end
            if (!done) begin
               if (it.overtemp_flag) begin
                  if (otw_lock == 0) begin
                     otw_lock = cfg_otw;
                     r.reduce = 1'b1;
                     done = 1'b1;
                  end
               end else begin
                  otw_lock = '0;
               end
            end
            if (!done && it.clip_flag && clip_lock == 0) begin
               clip_lock = cfg_clip;
               if (tgt_known && int'(tgt) - int'(it.measured) <= int'(cfg_headroom) &&
                   tgt < cfg_max) begin
                  raised = ({16'd0, tgt} * 32'd11 + 32'd5) / 32'd10;
                  if (raised > {16'd0, cfg_max}) raised = {16'd0, cfg_max};
                  r.written = apply_target(raised[15:0]);
               end
            end
         end
      endcase
      r.target = tgt_known ? tgt : 16'd0;
      return r;
   endfunction

   // Mostly zero, sometimes short, now and then a long stretch.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 15);
      if (r < 9) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_item(input policy_item_type it);
      int gap;
      @(negedge clock);
      gap = gap_enable ? idle_length() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= it.mode;
      req_volume_db <= it.volume;
      req_power_on <= it.power_on;
      req_amp_warn <= it.amp_warn;
      req_overtemp_flag <= it.overtemp_flag;
      req_clip_flag <= it.clip_flag;
      req_measured_supply_mv <= it.measured;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      expected_supply = {expected_supply, predict_supply_step(it)};
   endtask

   task automatic send_fields(input mode_type mode, input int vol, input logic pwr,
                              input logic warn, input logic otw, input logic clip,
                              input int meas);
      policy_item_type it;
      it.mode = mode;
      it.volume = vol[11:0];
      it.power_on = pwr;
      it.amp_warn = warn;
      it.overtemp_flag = otw;
      it.clip_flag = clip;
      it.measured = meas[15:0];
      send_item(it);
   endtask

   // Lower valid, wait for every outstanding transaction to come back, then let
   // the pipeline settle.
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_supply.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input mv_type data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         CSR_SUPPLY_MIN:    cfg_min = data;
         CSR_SUPPLY_MAX:    cfg_max = data;
         CSR_FULL_VOLUME:   cfg_knee = data[11:0];
         CSR_LOWER_LOCK:    cfg_lower = data;
         CSR_CLIP_LOCK:     cfg_clip = data;
         CSR_OTW_LOCK:      cfg_otw = data;
         CSR_WARN_LOCK:     cfg_warn = data;
         CSR_CLIP_HEADROOM: cfg_headroom = data;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic program_policy(input int min_mv, input int max_mv, input int knee,
                                 input int lower, input int clip, input int otw,
                                 input int warn, input int headroom);
      drain();
      write_csr(CSR_SUPPLY_MIN, min_mv[15:0]);
      write_csr(CSR_SUPPLY_MAX, max_mv[15:0]);
      write_csr(CSR_FULL_VOLUME, knee[15:0]);
      write_csr(CSR_LOWER_LOCK, lower[15:0]);
      write_csr(CSR_CLIP_LOCK, clip[15:0]);
      write_csr(CSR_OTW_LOCK, otw[15:0]);
      write_csr(CSR_WARN_LOCK, warn[15:0]);
      write_csr(CSR_CLIP_HEADROOM, headroom[15:0]);
   endtask

   function automatic int pick_value(int lo, int hi, int extreme_hi);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 0;
      if (r == 1) return extreme_hi;
      return $urandom_range(lo, hi);
   endfunction

   function automatic policy_item_type random_item();
      policy_item_type it;
      int r, v, m;
      r = $urandom_range(0, 19);
      if (r < 7) it.mode = MODE_TICK;
      else if (r < 13) it.mode = MODE_VOLUME;
      else if (r < 18) it.mode = MODE_STATUS;
      else it.mode = MODE_POWER;
      // Volumes cluster around the full supply point so the gain table is exercised.
      if ($urandom_range(0, 4) != 0)
         v = int'(cfg_knee) - int'($urandom_range(0, 1100)) + int'($urandom_range(0, 40));
      else
         v = int'($urandom_range(0, 2559)) - 2048;
      if (v < -2048) v = -2048;
      if (v > 511) v = 511;
      it.volume = v[11:0];
      it.power_on = $urandom_range(0, 2) != 0;
      it.amp_warn = $urandom_range(0, 3) == 0;
      it.overtemp_flag = $urandom_range(0, 3) == 0;
      it.clip_flag = $urandom_range(0, 1) == 0;
      if ($urandom_range(0, 1) == 0) begin
         m = int'(tgt) - int'($urandom_range(0, int'(cfg_headroom) + 2000)) +
             int'($urandom_range(0, 2000));
         if (m < 0) m = 0;
         if (m > 65535) m = 65535;
      end else begin
         m = $urandom_range(0, 65535);
      end
      it.measured = m[15:0];
      return it;
   endfunction

   // Result checker: each transaction against the oldest prediction.
   always @(posedge clock) begin
      supply_result_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_supply.size() == 0) begin
            $display("%0t: unexpected result, target %0d", $time, rsp_supply_target_mv);
            errors++;
         end else begin
            e = expected_supply[0];
            expected_supply.delete(0);
            if (rsp_supply_target_mv !== e.target) begin
               $display("%0t: supply_target_mv expected %0d actual %0d",
                        $time, e.target, rsp_supply_target_mv);
               errors++;
            end
            if (rsp_target_written !== e.written) begin
               $display("%0t: target_written expected %0b actual %0b",
                        $time, e.written, rsp_target_written);
               errors++;
            end
            if (rsp_reduce_volume !== e.reduce) begin
               $display("%0t: reduce_volume expected %0b actual %0b",
                        $time, e.reduce, rsp_reduce_volume);
               errors++;
            end
            if (rsp_safety_event !== e.safety) begin
               $display("%0t: safety_event expected %0b actual %0b",
                        $time, e.safety, rsp_safety_event);
               errors++;
            end
         end
      end
   end

   // Receiver stall generator; a requested hold-off takes precedence.
   always begin
      int n;
      @(negedge clock);
      if (hold_cycles > 0) begin
         n = hold_cycles;
         hold_cycles = 0;
         rsp_stall <= 1'b1;
      end else begin
         n = stall_enable ? idle_length() : 0;
         rsp_stall <= (n > 0);
         if (n == 0) n = 1;
      end
      repeat (n - 1) @(negedge clock);
   end

   // Reset values, extreme volumes, warnings and power changes.
   task automatic test_default_policy();
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 0);
      send_fields(MODE_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, 511, 1'b1, 1'b1, 1'b1, 1'b1, 65535);
      send_fields(MODE_VOLUME, -32, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -33, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -200, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b1, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b1, 1'b1, 65535);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b1, 1'b0, 0);
      send_fields(MODE_POWER, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_POWER, 0, 1'b1, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, 100, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_POWER, 0, 1'b1, 1'b0, 1'b0, 1'b0, 0);
   endtask

   // Short locks: lowering lock expiry on a tick and the clipping response.
   task automatic test_lock_expiry_and_clip();
      program_policy(15000, 50000, -32, 2, 1, 2, 2, 5000);
      send_fields(MODE_VOLUME, 511, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, 511, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 15000);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 16500);
      send_fields(MODE_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 0);
      send_fields(MODE_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b1, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b1, 1'b1, 20000);
      send_fields(MODE_VOLUME, 511, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 50000);
   endtask

   // Minimum above maximum, then zero reloads that keep every lock open.
   task automatic test_odd_limits();
      program_policy(60000, 1000, -32, 5, 5, 5, 5, 5000);
      send_fields(MODE_VOLUME, 511, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_POWER, 0, 1'b1, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 60000);
      program_policy(1000, 40000, 0, 0, 0, 0, 0, 0);
      send_fields(MODE_POWER, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -100, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, -300, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 5000);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 5000);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b1, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b1, 1'b0, 0);
   endtask

   // All-zero and all-ones register settings, but for the knee at -2048 and 511.
   task automatic test_register_extremes();
      program_policy(0, 0, -2048, 0, 0, 0, 0, 0);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, 511, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b0, 1'b0, 1'b1, 0);
      program_policy(65535, 65535, 511, 65535, 65535, 65535, 65535, 65535);
      send_fields(MODE_VOLUME, -2048, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_VOLUME, 511, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_STATUS, 0, 1'b0, 1'b1, 1'b1, 1'b1, 0);
      send_fields(MODE_TICK, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
      send_fields(MODE_POWER, 0, 1'b0, 1'b0, 1'b0, 1'b0, 0);
   endtask

   // The receiver holds off while the sender keeps offering transactions.
   task automatic test_backpressure();
      drain();
      stall_enable = 1'b0;
      gap_enable = 1'b0;
      repeat (3) @(posedge clock);
      hold_cycles = 80;
      repeat (30) send_item(random_item());
   endtask

   task automatic test_random_phases();
      int knee;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         knee = int'($urandom_range(0, 2559)) - 2048;
         if ($urandom_range(0, 2) != 0) knee = int'($urandom_range(0, 700)) - 600;
         program_policy(pick_value(0, 30000, 65535), pick_value(20000, 65535, 65535),
                        knee, pick_value(0, 30, 65535), pick_value(0, 20, 65535),
                        pick_value(0, 30, 65535), pick_value(0, 30, 65535),
                        pick_value(0, 10000, 65535));
         // The first phase runs without idling on either side.
         gap_enable = (phase != 0);
         stall_enable = (phase != 0);
         repeat (PHASE_ITEMS) send_item(random_item());
      end
   endtask

   initial begin
      reset_policy_model();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_default_policy();
      gap_enable = 1'b1;
      stall_enable = 1'b1;
      test_lock_expiry_and_clip();
      test_odd_limits();
      test_register_extremes();
      test_random_phases();
      test_backpressure();
      drain();
      if (errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT * CLOCK_PERIOD / 20);
      $display("simulation failed");
      $finish;
   end

endmodule
